FILE: hdl/assert_macros.svh
// assertion helpers for the checker in tcw_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is low
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw check failed");

// next-cycle implication, masked while reset is low
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw check failed");

// next-cycle implication that also holds across reset
`define TCW_ASSERT_NEXT_NR(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tcw check failed");

`endif

FILE: hdl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  localparam int CUR_W  = 12;
  localparam int CELL_W = 16;
  localparam int IDX_W  = 11;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // control codes, plus the space used for blanking
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic             action;
    logic [7:0]       char_code;
    logic [7:0]       color;
    logic [IDX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [CUR_W-1:0]  cursor;
    logic [CELL_W-1:0] cell_word;
  } out_item_t;

endpackage
`default_nettype wire

FILE: hdl/tcw_ram.sv
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/tcw_cmod.sv
`default_nettype none
module tcw_cmod #(
  parameter int DIVISOR = 8,
  parameter int XW      = 8
) (
  input  logic                                                   clk,
  input  logic [XW-1:0]                                          x,
  output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0]       rem
);

  localparam int RW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
  localparam int M  = (1 << XW) / DIVISOR;
  localparam int MW = $clog2(M + 1);
  localparam int PW = XW + MW;

  // x must hold steady while it passes through prod_r and then qd_r, before rem is used
  logic [PW-1:0] prod_r;
  logic [XW-1:0] qd_r;
  logic [MW-1:0] q;
  logic [XW-1:0] diff;
  logic [XW-1:0] fix;

  // reciprocal estimate is the true quotient or one below it
  assign q = prod_r[PW-1:XW];

  always_ff @(posedge clk) begin
    prod_r <= PW'(x) * PW'(M);
    qd_r   <= XW'(PW'(q) * PW'(DIVISOR));
  end

  assign diff = x - qd_r;
  assign fix  = (diff >= XW'(DIVISOR)) ? diff - XW'(DIVISOR) : diff;
  assign rem  = RW'(fix);

endmodule
`default_nettype wire

FILE: hdl/text_console_char_writer.sv
`default_nettype none
// text console writer: a COLUMNS x ROWS screen of 16-bit cells (color byte over character
// byte) held in one simple dual-port ram, plus a cursor register. A put item first scrolls
// the screen when the cursor sits at or past the screen end, then handles the character:
// carriage return, newline, backspace, tab, vertical tab and bell are control codes, any
// other byte is written at the cursor, which then advances. A read item returns one cell
// (0 beyond the screen). Every item gives exactly one result item carrying the cursor.
// A bell is a read-modify-write of the cell. Carriage return, newline, vertical tab and tab
// first wait for the cursor column from a pipelined multiply-by-reciprocal unit; a tab then
// writes its spaces one per cycle unless a scroll comes between. A scroll walks the ram one
// cell per cycle (one read and one write port). After reset the ram is zeroed by a clearing
// pass over all COLUMNS*ROWS cells (2000 by default) during which in_stall stays high.
// A finished result waits in an output register, so the next item is taken while the
// previous result is still stalled.
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int N        = COLUMNS * ROWS;
  localparam int AW       = $clog2(N);
  localparam int CW       = $clog2(COLUMNS);
  localparam int TW       = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int CNT_W    = $clog2(TAB_WIDTH + 1);
  localparam int COPY_LEN = N - COLUMNS;

  localparam logic [CUR_W-1:0] SCROLL_CUR = CUR_W'(N - COLUMNS);
  localparam logic [CUR_W-1:0] LF_OFS     = CUR_W'(COLUMNS);
  localparam logic [CUR_W-1:0] VT_OFS     = CUR_W'(TAB_WIDTH * COLUMNS);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_READ  = 12'b0000_0000_0100,
    S_CHECK = 12'b0000_0000_1000,
    S_COPY  = 12'b0000_0001_0000,
    S_FILL  = 12'b0000_0010_0000,
    S_MOD   = 12'b0000_0100_0000,
    S_EXEC  = 12'b0000_1000_0000,
    S_TMOD  = 12'b0001_0000_0000,
    S_TAB   = 12'b0010_0000_0000,
    S_BELL  = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  // sequencer state
  state_t            state_r,  state_nxt;
  state_t            ret_r,    ret_nxt;    // where a scroll hands back control
  logic [AW-1:0]     k_r,      k_nxt;      // sweep counter for clear, copy and fill
  logic [1:0]        wait_r,   wait_nxt;   // latency of the modulo units
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;

  // item payload
  in_item_t          item_r,   item_nxt;
  logic [CELL_W-1:0] word_r,   word_nxt;
  logic [CW-1:0]     col_r,    col_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;    // tab spaces still to write

  // result register
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r,  out_item_nxt;

  // screen ram ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] rd_data;

  logic [CW-1:0]     col_rem;
  logic [TW-1:0]     tab_rem;

  logic              in_acc;
  logic              out_free;
  logic              cursor_ge;
  logic              needs_col;
  logic [CUR_W-1:0]  row_start;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (N)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // cursor column, cursor mod COLUMNS
  tcw_cmod #(
    .DIVISOR (COLUMNS),
    .XW      (CUR_W)
  ) u_col_mod (
    .clk (clk),
    .x   (cursor_r),
    .rem (col_rem)
  );

  // tab stop phase, column mod TAB_WIDTH
  tcw_cmod #(
    .DIVISOR (TAB_WIDTH),
    .XW      (8)
  ) u_tab_mod (
    .clk (clk),
    .x   (8'(col_r)),
    .rem (tab_rem)
  );

  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cursor_ge = 32'(cursor_r) >= N;
  assign row_start = cursor_r - CUR_W'(col_r);

  // only these codes look at the cursor column
  assign needs_col = (item_r.char_code == CH_CR) || (item_r.char_code == CH_LF) ||
                     (item_r.char_code == CH_VT) || (item_r.char_code == CH_TAB);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    k_nxt         = k_r;
    wait_nxt      = wait_r;
    cursor_nxt    = cursor_r;
    item_nxt      = item_r;
    word_nxt      = word_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      // zero the screen one cell per cycle after reset
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        if (k_r == AW'(N - 1)) begin
          k_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          item_nxt = in_item;
          word_nxt = '0;
          if (in_item.action == ACT_READ) begin
            // out-of-range reads skip the ram and return zero later
            ram_re    = 32'(in_item.cell_index) < N;
            ram_raddr = AW'(in_item.cell_index);
            state_nxt = S_READ;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end

      S_READ: begin
        word_nxt  = (32'(item_r.cell_index) < N) ? rd_data : '0;
        state_nxt = S_DONE;
      end

      // scroll check ahead of every put
      S_CHECK: begin
        wait_nxt = '0;
        if (cursor_ge) begin
          k_nxt     = '0;
          ret_nxt   = needs_col ? S_MOD : S_EXEC;
          state_nxt = S_COPY;
        end else begin
          state_nxt = needs_col ? S_MOD : S_EXEC;
        end
      end

      // move rows up: read cell k+COLUMNS, write the previous read to cell k-1
      S_COPY: begin
        if (k_r != AW'(COPY_LEN)) begin
          ram_re    = 1'b1;
          ram_raddr = k_r + AW'(COLUMNS);
        end
        if (k_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = k_r - 1'b1;
          ram_wdata = rd_data;
        end
        if (k_r == AW'(COPY_LEN)) begin
          state_nxt = S_FILL;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // blank the last row in the item's color
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = {item_r.color, CH_SPACE};
        if (k_r == AW'(N - 1)) begin
          cursor_nxt = SCROLL_CUR;
          wait_nxt   = '0;
          state_nxt  = ret_r;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // wait out the column unit, cursor is steady meanwhile
      S_MOD: begin
        wait_nxt = wait_r + 1'b1;
        if (wait_r == 2'd2) begin
          col_nxt   = col_rem;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        wait_nxt  = '0;
        state_nxt = S_DONE;
        unique case (item_r.char_code)
          CH_CR: cursor_nxt = row_start;
          CH_LF: cursor_nxt = row_start + LF_OFS;
          CH_VT: cursor_nxt = row_start + VT_OFS;
          CH_BS: begin
            if (cursor_r != '0) begin
              cursor_nxt = cursor_r - 1'b1;
            end
          end
          CH_TAB: state_nxt = S_TMOD;
          CH_BEL: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(cursor_r);
            state_nxt = S_BELL;
          end
          default: begin
            ram_we     = 1'b1;
            ram_waddr  = AW'(cursor_r);
            ram_wdata  = {item_r.color, item_r.char_code};
            cursor_nxt = cursor_r + 1'b1;
          end
        endcase
      end

      // number of spaces up to the next tab stop
      S_TMOD: begin
        wait_nxt = wait_r + 1'b1;
        if (wait_r == 2'd2) begin
          cnt_nxt   = CNT_W'(TAB_WIDTH) - CNT_W'(tab_rem);
          state_nxt = S_TAB;
        end
      end

      // one space per cycle unless a scroll comes between, each with its own scroll check
      S_TAB: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else if (cursor_ge) begin
          k_nxt     = '0;
          ret_nxt   = S_TAB;
          state_nxt = S_COPY;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = AW'(cursor_r);
          ram_wdata  = {item_r.color, CH_SPACE};
          cursor_nxt = cursor_r + 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end

      // invert the color, keep the character
      S_BELL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cursor_r);
        ram_wdata = {~item_r.color, rd_data[7:0]};
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.cursor    = cursor_r;
          out_item_nxt.cell_word = word_r;
          state_nxt              = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ret_r       <= S_EXEC;
      k_r         <= '0;
      wait_r      <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      k_r         <= k_nxt;
      wait_r      <= wait_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    word_r     <= word_nxt;
    col_r      <= col_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

FILE: hdl/tcw_chk.sv
`default_nettype none
`include "assert_macros.svh"
module tcw_chk
  import tcw_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // no result without an item behind it
  `TCW_ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, pend_r != 2'd0)
  // a new item only enters when at most one result is waiting
  `TCW_ASSERT_IMP(a_one_in_flight, clk, rst_n, in_acc, pend_r <= 2'd1)
  // the clearing pass blocks input right after reset
  `TCW_ASSERT_NEXT_NR(a_clear_stall, clk, !rst_n, in_stall)
  // a stalled result holds
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_item))

endmodule

bind text_console_char_writer tcw_chk u_tcw_chk (.*);
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  // screen geometry, kept equal to the block's defaults
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int TAB_WIDTH    = 8;
  localparam int SCREEN_CELLS = COLUMNS * ROWS;
  localparam int CURSOR_MASK  = 12'hFFF;
  localparam int IN_W         = $bits(in_item_t);

  // longest stretch with no handshake: clearing pass or a scroll, with plenty of slack
  localparam int HANDSHAKE_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // predicted console state
  logic [15:0] screen_model [0:SCREEN_CELLS-1];
  int          cursor_model;

  // cursor and cell words still owed by the block, oldest first
  out_item_t console_results_due [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int quiet_cycles   = 0;

  text_console_char_writer #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // console prediction
  // ---------------------------------------------------------------------------

  // scroll up one row when the cursor has run off the screen end
  task automatic scroll_screen_model(input logic [7:0] color);
    if (cursor_model >= SCREEN_CELLS) begin
      for (int i = 0; i < SCREEN_CELLS - COLUMNS; i++)
        screen_model[i] = screen_model[i + COLUMNS];
      // last row blanked with spaces in the item's color
      for (int i = SCREEN_CELLS - COLUMNS; i < SCREEN_CELLS; i++)
        screen_model[i] = {color, CH_SPACE};
      cursor_model = SCREEN_CELLS - COLUMNS;
    end
  endtask

  task automatic write_cell_model(input logic [7:0] ch, input logic [7:0] color);
    screen_model[cursor_model] = {color, ch};
    cursor_model = (cursor_model + 1) & CURSOR_MASK;
  endtask

  task automatic predict_console_output(input in_item_t item, output out_item_t res);
    int row_start;
    int spaces;
    res = '0;
    if (item.action == ACT_READ) begin
      // cells past the screen end read as zero
      if (int'(item.cell_index) < SCREEN_CELLS)
        res.cell_word = screen_model[item.cell_index];
    end else begin
      scroll_screen_model(item.color);
      row_start = cursor_model - (cursor_model % COLUMNS);
      case (item.char_code)
        CH_CR: cursor_model = row_start;
        CH_LF: cursor_model = (row_start + COLUMNS) & CURSOR_MASK;
        CH_BS: begin
          // nothing happens at cell zero
          if (cursor_model > 0)
            cursor_model = cursor_model - 1;
        end
        CH_TAB: begin
          // spaces up to the next tab stop, each one its own put
          spaces = TAB_WIDTH - ((cursor_model % COLUMNS) % TAB_WIDTH);
          for (int k = 0; k < spaces; k++) begin
            scroll_screen_model(item.color);
            write_cell_model(CH_SPACE, item.color);
          end
        end
        CH_VT: cursor_model = (row_start + TAB_WIDTH * COLUMNS) & CURSOR_MASK;
        CH_BEL: begin
          // inverted color, character kept, cursor stays
          screen_model[cursor_model] = {~item.color, screen_model[cursor_model][7:0]};
        end
        default: write_cell_model(item.char_code, item.color);
      endcase
    end
    res.cursor = cursor_model[CUR_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // sender: one item per call, entered and left at a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_item(input in_item_t item);
    out_item_t res;
    // random idle cycles before the item, payload scrambled while invalid
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_item  <= IN_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    predict_console_output(item, res);
    console_results_due.push_back(res);
    @(negedge clk);
  endtask

  task automatic send_put(input logic [7:0] ch, input logic [7:0] color);
    in_item_t item;
    item.action     = ACT_PUT;
    item.char_code  = ch;
    item.color      = color;
    item.cell_index = IDX_W'($urandom);
    send_item(item);
  endtask

  task automatic send_read(input int idx);
    in_item_t item;
    item.action     = ACT_READ;
    item.char_code  = 8'($urandom);
    item.color      = 8'($urandom);
    item.cell_index = idx[IDX_W-1:0];
    send_item(item);
  endtask

  // ---------------------------------------------------------------------------
  // receiver stall and result checking
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (console_results_due.size() == 0) begin
        $display("%t unexpected item: cursor %0d cell %h", $time,
                 out_item.cursor, out_item.cell_word);
        error_count++;
      end else begin
        want = console_results_due.pop_front();
        if (out_item.cursor !== want.cursor) begin
          $display("%t cursor mismatch: expected %0d actual %0d", $time,
                   want.cursor, out_item.cursor);
          error_count++;
        end
        if (out_item.cell_word !== want.cell_word) begin
          $display("%t cell_word mismatch: expected %h actual %h", $time,
                   want.cell_word, out_item.cell_word);
          error_count++;
        end
      end
    end
  end

  // watchdog: any handshake on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANDSHAKE_LIMIT) begin
      $display("%t timeout: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every control code, field extremes, scrolls and out-of-screen reads
  task automatic test_directed_controls();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_put(CH_BS, 8'hFF);         // backspace at cell zero
    send_read(0);                   // cleared screen
    send_put(8'hFF, 8'hFF);
    send_put(8'h00, 8'h00);
    send_read(0);
    send_read(1);
    send_put(CH_BS, 8'h55);         // back onto cell 1
    send_put(CH_BEL, 8'h0F);        // invert color, keep character
    send_read(1);
    send_put(CH_TAB, 8'h33);        // partial tab from column 1
    send_put(CH_TAB, 8'hCC);        // full tab from a tab stop
    send_put(CH_CR, 8'h01);
    send_put(CH_LF, 8'h02);
    send_put(8'h41, 8'h07);
    send_put(CH_VT, 8'h10);         // row 9
    send_put(CH_VT, 8'h20);         // row 17
    send_put(CH_VT, 8'h40);         // past the last row
    send_read(SCREEN_CELLS - 1);
    send_put(8'h42, 8'h1E);         // scroll, then write
    send_read(SCREEN_CELLS - COLUMNS + 1);
    send_read(0);                   // old row 1 moved to row 0
    send_read(SCREEN_CELLS);        // beyond the screen
    send_read((1 << IDX_W) - 1);
    send_put(CH_VT, 8'h5A);         // cursor well past the screen end
    send_put(CH_CR, 8'hA5);         // scroll on a control code
    send_put(CH_LF, 8'h80);
    send_put(CH_TAB, 8'h81);        // scroll on a tab
    send_put(8'h7F, 8'hAA);
  endtask

  // mixed puts and reads, control codes weighted up, reads often near the cursor
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    in_item_t item;
    int       pick;
    int       near;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      item.action     = ACT_PUT;
      item.char_code  = 8'($urandom);
      item.color      = 8'($urandom);
      item.cell_index = IDX_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        item.action = ACT_READ;
        if ($urandom_range(0, 1) == 1) begin
          near = cursor_model - int'($urandom_range(0, 40));
          if (near < 0)
            near = 0;
          if (near > (1 << IDX_W) - 1)
            near = (1 << IDX_W) - 1;
          item.cell_index = near[IDX_W-1:0];
        end
      end else if (pick < 28) begin
        item.char_code = CH_LF;
      end else if (pick < 32) begin
        item.char_code = CH_CR;
      end else if (pick < 36) begin
        item.char_code = CH_BS;
      end else if (pick < 42) begin
        item.char_code = CH_TAB;
      end else if (pick < 44) begin
        item.char_code = CH_VT;
      end else if (pick < 48) begin
        item.char_code = CH_BEL;
      end
      send_item(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < SCREEN_CELLS; i++)
      screen_model[i] = '0;
    cursor_model = 0;

    // single reset at the start; the block then clears its ram on its own
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_controls();
    test_random_traffic(325, 0, 0);
    test_random_traffic(325, 55, 0);
    test_random_traffic(325, 0, 55);
    test_random_traffic(325, 23, 23);

    // drain: wait for everything owed, then keep watching for stray items
    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (console_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: text_console_char_writer.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_cmod.sv
hdl/text_console_char_writer.sv
hdl/tcw_chk.sv
bench/testbench.sv
